>>> rtl/wss_pkg.sv
// ----------------------------------------------------------------------------
// wss_pkg
// Shared constants, types and helpers for the waypoint smoothstep
// interpolator: store geometry, fixed-point widths, opcodes and the
// divider request/response words.
// ----------------------------------------------------------------------------
package wss_pkg;

  // Store geometry and fixed-point format
  localparam int MAX_POINTS = 64;
  localparam int JOINTS     = 6;
  localparam int FRAC_BITS  = 16;

  // Fixed port layout
  localparam int OUT_JOINTS = 6;
  localparam int ELEM_W     = 32;
  localparam int DUR_W      = 16;
  localparam int CNT_W      = 7;
  localparam int OP_W       = 2;
  localparam int IDX_W      = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Derived widths
  localparam int PT_W    = $clog2(MAX_POINTS);
  localparam int ADDR_W  = $clog2(MAX_POINTS * JOINTS);
  localparam int JI_W    = $clog2(OUT_JOINTS);
  localparam int K_W     = FRAC_BITS + 2;
  localparam int MUL_A_W = ELEM_W + 2;
  localparam int MUL_B_W = FRAC_BITS + 2;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int DVD_W   = ELEM_W + FRAC_BITS;
  localparam int DCNT_W  = $clog2(DVD_W + 1);
  localparam int ONE     = 1 << FRAC_BITS;

  // Register reset values
  localparam logic [DUR_W-1:0] DUR_RESET = DUR_W'(1000);
  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(2);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SEG_DUR   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_CNT = 1'd1;

  // Operation codes
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_START = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

  // Divider request and response
  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [DUR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DVD_W-1:0]  quotient;
  } div_rsp_t;

  // Flat store address of joint j of waypoint pt
  function automatic logic [ADDR_W-1:0] wp_addr(logic [PT_W-1:0] pt, logic [JI_W-1:0] j);
    return ADDR_W'(pt) * ADDR_W'(JOINTS) + ADDR_W'(j);
  endfunction

endpackage

>>> rtl/wss_store.sv
// ----------------------------------------------------------------------------
// wss_store
// Waypoint memory: one joint word per entry, one write and one read port,
// registered read data.
// ----------------------------------------------------------------------------
module wss_store
  import wss_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [ELEM_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [ELEM_W-1:0] rdata
);

  logic [ELEM_W-1:0] mem [MAX_POINTS*JOINTS];
  logic [ELEM_W-1:0] rdata_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/wss_div.sv
// ----------------------------------------------------------------------------
// wss_div
// Restoring divider, one quotient bit per cycle. The dividend register
// shifts left and collects quotient bits at the bottom.
// ----------------------------------------------------------------------------
module wss_div
  import wss_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy_r;
  logic              done_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [DVD_W-1:0]  quo_r;
  logic [DUR_W:0]    rem_r;
  logic [DUR_W-1:0]  dvs_r;

  logic [DUR_W:0]    rem_sh;
  logic              q_bit;
  logic [DUR_W:0]    rem_nxt;

  // One restoring step
  always_comb begin
    rem_sh  = {rem_r[DUR_W-1:0], quo_r[DVD_W-1]};
    q_bit   = (rem_sh >= {1'b0, dvs_r});
    rem_nxt = q_bit ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
  end

  // Control: iteration count and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DCNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DVD_W-2:0], q_bit};
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

>>> rtl/wss_mul.sv
// ----------------------------------------------------------------------------
// wss_mul
// Shared signed multiplier with a registered product. Serves the segment
// end time, the smoothstep polynomial and the per-joint scaling.
// ----------------------------------------------------------------------------
module wss_mul
  import wss_pkg::*;
(
  input  logic                      clk,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic signed [PROD_W-1:0]  prod
);

  logic signed [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

  assign prod = prod_r;

endmodule

>>> rtl/waypoint_smoothstep_interpolator_top.sv
// ----------------------------------------------------------------------------
// waypoint_smoothstep_interpolator_top
// Six-joint waypoint trajectory generator with smoothstep blending.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (in_valid / in_stall) carry an operation: load writes one
//   waypoint into the store, start emits waypoint 0 and arms the motion,
//   tick carries elapsed ms and emits one blended position (or the last
//   waypoint with out_finished set once the path time is used up).
//   Result words leave on out_valid / out_stall, held in an output register.
//   Configuration (segment duration, point count) is written on cfg_we; the
//   user must do so only while the block is idle, the block does not check.
// Timing:
//   One word at a time; in_stall is high until the word is done.
//   Load: one store write per joint. Start: S_ERD and S_ECAP per joint
//   read. Tick: set by the bit-serial divider plus S_RDA, S_RDB, S_MUL and
//   S_ACC per joint on the shared multiplier and single store read port.
//   A result passes from S_OUT into the output register; a new word is
//   taken while it waits. If the receiver stalls and a new result is ready,
//   the block holds in its last state until the register frees up.
// Reset: motion idle, no result pending, duration 1000 ms, count 2. The
//   waypoint store is not cleared.
// ----------------------------------------------------------------------------
module waypoint_smoothstep_interpolator_top
  import wss_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  // configuration
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_wdata,
  // input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [OP_W-1:0]          in_operation,
  input  logic [IDX_W-1:0]         in_point_index,
  input  logic signed [ELEM_W-1:0] in_joint_in_0,
  input  logic signed [ELEM_W-1:0] in_joint_in_1,
  input  logic signed [ELEM_W-1:0] in_joint_in_2,
  input  logic signed [ELEM_W-1:0] in_joint_in_3,
  input  logic signed [ELEM_W-1:0] in_joint_in_4,
  input  logic signed [ELEM_W-1:0] in_joint_in_5,
  input  logic [ELEM_W-1:0]        in_elapsed_ms,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [ELEM_W-1:0] out_joint_out_0,
  output logic signed [ELEM_W-1:0] out_joint_out_1,
  output logic signed [ELEM_W-1:0] out_joint_out_2,
  output logic signed [ELEM_W-1:0] out_joint_out_3,
  output logic signed [ELEM_W-1:0] out_joint_out_4,
  output logic signed [ELEM_W-1:0] out_joint_out_5,
  output logic                     out_finished
);

  // Sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOAD  = 4'd1;
  localparam logic [3:0] S_ERD   = 4'd2;
  localparam logic [3:0] S_ECAP  = 4'd3;
  localparam logic [3:0] S_TOTAL = 4'd4;
  localparam logic [3:0] S_CMP   = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_SQ    = 4'd7;
  localparam logic [3:0] S_POLY  = 4'd8;
  localparam logic [3:0] S_SCALE = 4'd9;
  localparam logic [3:0] S_RDA   = 4'd10;
  localparam logic [3:0] S_RDB   = 4'd11;
  localparam logic [3:0] S_MUL   = 4'd12;
  localparam logic [3:0] S_ACC   = 4'd13;
  localparam logic [3:0] S_OUT   = 4'd14;

  // Control state
  logic [3:0]           state_r, state_nxt;
  logic                 running_r, running_nxt;
  logic [JI_W-1:0]      j_r, j_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [DUR_W-1:0]     seg_dur_r;
  logic [CNT_W-1:0]     point_cnt_r;

  // Payload registers
  logic [IDX_W-1:0]     idx_r;
  logic [ELEM_W-1:0]    jin_r [OUT_JOINTS];
  logic [ELEM_W-1:0]    elapsed_r;
  logic [PT_W-1:0]      pt_r;
  logic                 fin_r;
  logic [PT_W-1:0]      seg_r;
  logic [FRAC_BITS-1:0] t_r;
  logic [FRAC_BITS-1:0] s_r;
  logic [ELEM_W-1:0]    a_r;
  logic [ELEM_W-1:0]    res_r [OUT_JOINTS];
  logic [ELEM_W-1:0]    out_joint_r [OUT_JOINTS];
  logic                 out_fin_r;

  // Shared units and store
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_prod;
  logic                      store_we;
  logic [ADDR_W-1:0]         store_waddr;
  logic [ADDR_W-1:0]         store_raddr;
  logic [ELEM_W-1:0]         store_rdata;

  // Helpers
  logic                 in_acc;
  logic [CNT_W-1:0]     cnt_use;
  logic                 cfg_ok;
  logic                 slot_ok;
  logic                 last_j;
  logic                 end_hit;
  logic [K_W-1:0]       k_val;
  logic [ELEM_W:0]      diff;

  wss_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  wss_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (mul_prod)
  );

  wss_store u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_waddr),
    .wdata (jin_r[j_r]),
    .raddr (store_raddr),
    .rdata (store_rdata)
  );

  // Handshake and derived terms
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    if (int'(point_cnt_r) > MAX_POINTS) begin
      cnt_use = CNT_W'(MAX_POINTS);
    end else begin
      cnt_use = point_cnt_r;
    end
  end

  assign cfg_ok  = (seg_dur_r != '0) && (cnt_use >= CNT_W'(2));
  assign slot_ok = (int'(in_point_index) < MAX_POINTS);
  assign last_j  = (j_r == JI_W'(JOINTS - 1));
  assign end_hit = (PROD_W'(elapsed_r) >= $unsigned(mul_prod));
  assign k_val   = K_W'(3 * ONE) - {1'b0, t_r, 1'b0};
  assign diff    = {store_rdata[ELEM_W-1], store_rdata} - {a_r[ELEM_W-1], a_r};

  // Sequencer
  always_comb begin
    state_nxt        = state_r;
    running_nxt      = running_r;
    j_nxt            = j_r;
    out_valid_nxt    = out_valid_r;
    div_req.start    = 1'b0;
    div_req.dividend = {elapsed_r, {FRAC_BITS{1'b0}}};
    div_req.divisor  = seg_dur_r;
    mul_a            = '0;
    mul_b            = '0;
    store_we         = 1'b0;
    store_waddr      = wp_addr(PT_W'(idx_r), j_r);
    store_raddr      = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          j_nxt = '0;
          case (in_operation)
            OP_LOAD: begin
              if (slot_ok) begin
                state_nxt = S_LOAD;
              end
            end
            OP_START: begin
              if (cfg_ok) begin
                running_nxt = 1'b1;
                state_nxt   = S_ERD;
              end
            end
            OP_TICK: begin
              if (running_r) begin
                if (!cfg_ok) begin
                  running_nxt = 1'b0;
                end else begin
                  state_nxt = S_TOTAL;
                end
              end
            end
            default: ;
          endcase
        end
      end
      // write one joint word per cycle
      S_LOAD: begin
        store_we = 1'b1;
        j_nxt    = j_r + 1'b1;
        if (last_j) begin
          state_nxt = S_IDLE;
        end
      end
      // copy one stored waypoint to the result
      S_ERD: begin
        store_raddr = wp_addr(pt_r, j_r);
        state_nxt   = S_ECAP;
      end
      S_ECAP: begin
        j_nxt     = j_r + 1'b1;
        state_nxt = last_j ? S_OUT : S_ERD;
      end
      // path end time = duration * (count - 1)
      S_TOTAL: begin
        mul_a     = MUL_A_W'(seg_dur_r);
        mul_b     = MUL_B_W'(cnt_use - 1'b1);
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (end_hit) begin
          running_nxt = 1'b0;
          state_nxt   = S_ERD;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          state_nxt = S_SQ;
        end
      end
      // smoothstep: t*t, then t2*(3-2t)
      S_SQ: begin
        mul_a     = MUL_A_W'(t_r);
        mul_b     = MUL_B_W'(t_r);
        state_nxt = S_POLY;
      end
      S_POLY: begin
        mul_a     = MUL_A_W'(k_val);
        mul_b     = MUL_B_W'(mul_prod[2*FRAC_BITS-1:FRAC_BITS]);
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        state_nxt = S_RDA;
      end
      // per joint: read from, read to, scale difference, add
      S_RDA: begin
        store_raddr = wp_addr(seg_r, j_r);
        state_nxt   = S_RDB;
      end
      S_RDB: begin
        store_raddr = wp_addr(seg_r + 1'b1, j_r);
        state_nxt   = S_MUL;
      end
      S_MUL: begin
        mul_a     = {{(MUL_A_W-ELEM_W-1){diff[ELEM_W]}}, diff};
        mul_b     = MUL_B_W'(s_r);
        state_nxt = S_ACC;
      end
      S_ACC: begin
        j_nxt     = j_r + 1'b1;
        state_nxt = last_j ? S_OUT : S_RDA;
      end
      // hand the result to the output register
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      running_r   <= 1'b0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
      seg_dur_r   <= DUR_RESET;
      point_cnt_r <= CNT_RESET;
    end else begin
      state_r     <= state_nxt;
      running_r   <= running_nxt;
      j_r         <= j_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_SEG_DUR:   seg_dur_r   <= cfg_wdata[DUR_W-1:0];
          CFG_POINT_CNT: point_cnt_r <= cfg_wdata[CNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          idx_r     <= in_point_index;
          jin_r[0]  <= in_joint_in_0;
          jin_r[1]  <= in_joint_in_1;
          jin_r[2]  <= in_joint_in_2;
          jin_r[3]  <= in_joint_in_3;
          jin_r[4]  <= in_joint_in_4;
          jin_r[5]  <= in_joint_in_5;
          elapsed_r <= in_elapsed_ms;
          pt_r      <= '0;
          fin_r     <= 1'b0;
          for (int i = 0; i < OUT_JOINTS; i++) begin
            res_r[i] <= '0;
          end
        end
      end
      S_ECAP: res_r[j_r] <= store_rdata;
      S_CMP: begin
        pt_r  <= PT_W'(cnt_use - 1'b1);
        fin_r <= end_hit;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          seg_r <= div_rsp.quotient[FRAC_BITS +: PT_W];
          t_r   <= div_rsp.quotient[FRAC_BITS-1:0];
        end
      end
      S_SCALE: s_r <= mul_prod[2*FRAC_BITS-1:FRAC_BITS];
      S_RDB:   a_r <= store_rdata;
      S_ACC:   res_r[j_r] <= a_r + mul_prod[FRAC_BITS +: ELEM_W];
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          for (int i = 0; i < OUT_JOINTS; i++) begin
            out_joint_r[i] <= res_r[i];
          end
          out_fin_r <= fin_r;
        end
      end
      default: ;
    endcase
  end

  // Result ports
  assign out_valid       = out_valid_r;
  assign out_joint_out_0 = $signed(out_joint_r[0]);
  assign out_joint_out_1 = $signed(out_joint_r[1]);
  assign out_joint_out_2 = $signed(out_joint_r[2]);
  assign out_joint_out_3 = $signed(out_joint_r[3]);
  assign out_joint_out_4 = $signed(out_joint_r[4]);
  assign out_joint_out_5 = $signed(out_joint_r[5]);
  assign out_finished    = out_fin_r;

`ifndef SYNTHESIS
  // divider finishes only while the sequencer waits for it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV))
    else $error("divider done outside divide state");

  // a finished word is only shown once the motion has stopped
  a_fin_stops_motion: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid_r) && out_fin_r) |-> !running_r)
    else $error("finished word while motion still running");

  // blending only happens during a running motion
  a_blend_running: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RDA) |-> running_r)
    else $error("joint blend while idle");
`endif

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for waypoint_smoothstep_interpolator_top. Drives load,
// start and tick words with random idle and stall patterns, predicts each
// trajectory pose with a fixed-point smoothstep tracker and compares every
// result word field by field. Covers directed edge cases first, then random
// motions over a range of segment durations and point counts.
// ----------------------------------------------------------------------------
module testbench;
  import wss_pkg::*;

  localparam int RANDOM_WORDS = 1550;
  localparam int DRAIN_CYCLES = 200;
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  // One result word: six joint positions and the end-of-motion flag
  typedef struct {
    logic [ELEM_W-1:0] joint [OUT_JOINTS];
    logic              finished;
  } pose_t;

  // One input word
  typedef struct {
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  slot;
    logic [ELEM_W-1:0] joint [OUT_JOINTS];
    logic [ELEM_W-1:0] elapsed_ms;
  } cmd_t;

  // Tracks the waypoint store and motion state, predicts poses
  class trajectory_scoreboard;
    logic [ELEM_W-1:0] store [MAX_POINTS*JOINTS];
    bit                moving;
    logic [DUR_W-1:0]  seg_dur;
    logic [CNT_W-1:0]  pt_cnt;
    pose_t             poses_due [$];
    int unsigned       mismatches;

    function new();
      moving     = 1'b0;
      seg_dur    = DUR_RESET;
      pt_cnt     = CNT_RESET;
      mismatches = 0;
      foreach (store[i]) store[i] = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_SEG_DUR) seg_dur = val[DUR_W-1:0];
      else if (idx == CFG_POINT_CNT) pt_cnt = val[CNT_W-1:0];
    endfunction

    // count is clamped to the store size
    function int unsigned used_points();
      return (pt_cnt > MAX_POINTS) ? MAX_POINTS : int'(pt_cnt);
    endfunction

    function int unsigned poses_waiting();
      return poses_due.size();
    endfunction

    function pose_t waypoint_pose(int unsigned pt, logic fin);
      pose_t p;
      int    j;
      for (j = 0; j < OUT_JOINTS; j++)
        p.joint[j] = (j < JOINTS) ? store[(pt % MAX_POINTS) * JOINTS + j] : '0;
      p.finished = fin;
      return p;
    endfunction

    // Update state for an accepted word and queue the pose it produces
    function void note_word(cmd_t w);
      int unsigned       used;
      bit                cfg_ok;
      pose_t             p;
      longint unsigned   total, seg, local_ms, t, t2, s, dur, el;
      longint signed     diff, delta;
      logic [ELEM_W-1:0] a, b;
      int                j;
      used   = used_points();
      cfg_ok = (seg_dur != 0) && (used >= 2);
      case (w.op)
        OP_LOAD: begin
          for (j = 0; j < JOINTS; j++) store[w.slot * JOINTS + j] = w.joint[j];
        end
        OP_START: begin
          if (cfg_ok) begin
            moving = 1'b1;
            poses_due.push_back(waypoint_pose(0, 1'b0));
          end
        end
        OP_TICK: begin
          if (moving) begin
            if (!cfg_ok) begin
              moving = 1'b0;
            end else begin
              dur   = longint'(seg_dur);
              el    = longint'(w.elapsed_ms);
              total = dur * (used - 1);
              if (el >= total) begin
                moving = 1'b0;
                poses_due.push_back(waypoint_pose(used - 1, 1'b1));
              end else begin
                // segment, Q0.16 fraction, then s = t*t*(3-2t)
                seg      = el / dur;
                local_ms = el - seg * dur;
                t        = (local_ms << FRAC_BITS) / dur;
                t2       = (t * t) >> FRAC_BITS;
                s        = (t2 * (3 * ONE - 2 * t)) >> FRAC_BITS;
                for (j = 0; j < OUT_JOINTS; j++) begin
                  if (j < JOINTS) begin
                    a     = store[seg * JOINTS + j];
                    b     = store[(seg + 1) * JOINTS + j];
                    diff  = longint'($signed(b)) - longint'($signed(a));
                    delta = (diff * longint'(s)) >>> FRAC_BITS;
                    p.joint[j] = a + delta[ELEM_W-1:0];
                  end else begin
                    p.joint[j] = '0;
                  end
                end
                p.finished = 1'b0;
                poses_due.push_back(p);
              end
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_pose(pose_t got);
      pose_t want;
      int    j;
      if (poses_due.size() == 0) begin
        $error("result word with no pose expected (finished=%0b)", got.finished);
        mismatches++;
        return;
      end
      want = poses_due.pop_front();
      for (j = 0; j < OUT_JOINTS; j++) begin
        if (got.joint[j] !== want.joint[j]) begin
          $error("joint_out_%0d: expected %h, actual %h", j, want.joint[j], got.joint[j]);
          mismatches++;
        end
      end
      if (got.finished !== want.finished) begin
        $error("finished: expected %0b, actual %0b", want.finished, got.finished);
        mismatches++;
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_wdata = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [OP_W-1:0]          in_operation = '0;
  logic [IDX_W-1:0]         in_point_index = '0;
  logic signed [ELEM_W-1:0] in_joint_in_0 = '0;
  logic signed [ELEM_W-1:0] in_joint_in_1 = '0;
  logic signed [ELEM_W-1:0] in_joint_in_2 = '0;
  logic signed [ELEM_W-1:0] in_joint_in_3 = '0;
  logic signed [ELEM_W-1:0] in_joint_in_4 = '0;
  logic signed [ELEM_W-1:0] in_joint_in_5 = '0;
  logic [ELEM_W-1:0]        in_elapsed_ms = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [ELEM_W-1:0] out_joint_out_0;
  logic signed [ELEM_W-1:0] out_joint_out_1;
  logic signed [ELEM_W-1:0] out_joint_out_2;
  logic signed [ELEM_W-1:0] out_joint_out_3;
  logic signed [ELEM_W-1:0] out_joint_out_4;
  logic signed [ELEM_W-1:0] out_joint_out_5;
  logic                     out_finished;

  trajectory_scoreboard sb = new();
  int unsigned          words_sent = 0;
  int unsigned          send_idle_pct = 26;
  int unsigned          recv_idle_pct = 50;

  waypoint_smoothstep_interpolator_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_point_index  (in_point_index),
    .in_joint_in_0   (in_joint_in_0),
    .in_joint_in_1   (in_joint_in_1),
    .in_joint_in_2   (in_joint_in_2),
    .in_joint_in_3   (in_joint_in_3),
    .in_joint_in_4   (in_joint_in_4),
    .in_joint_in_5   (in_joint_in_5),
    .in_elapsed_ms   (in_elapsed_ms),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_joint_out_0 (out_joint_out_0),
    .out_joint_out_1 (out_joint_out_1),
    .out_joint_out_2 (out_joint_out_2),
    .out_joint_out_3 (out_joint_out_3),
    .out_joint_out_4 (out_joint_out_4),
    .out_joint_out_5 (out_joint_out_5),
    .out_finished    (out_finished)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver backpressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Result monitor
  always @(posedge clk) begin : result_mon
    pose_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.joint[0] = out_joint_out_0;
      got.joint[1] = out_joint_out_1;
      got.joint[2] = out_joint_out_2;
      got.joint[3] = out_joint_out_3;
      got.joint[4] = out_joint_out_4;
      got.joint[5] = out_joint_out_5;
      got.finished = out_finished;
      sb.check_pose(got);
    end
  end

  // Mix of extremes, values near zero and full-range noise
  function automatic logic [ELEM_W-1:0] joint_value();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return '0;
      3:       return $urandom_range(32'h0002_0000) - 32'h0001_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic cmd_t random_word(logic [OP_W-1:0] op);
    cmd_t w;
    int   j;
    w.op   = op;
    w.slot = IDX_W'($urandom_range(MAX_POINTS - 1));
    for (j = 0; j < OUT_JOINTS; j++) w.joint[j] = joint_value();
    w.elapsed_ms = $urandom();
    return w;
  endfunction

  task automatic send_word(input cmd_t w);
    // idle mix changes by thirds of the run
    if (words_sent < RANDOM_WORDS / 3) begin
      send_idle_pct = 26;
      recv_idle_pct = 50;
    end else if (words_sent < 2 * RANDOM_WORDS / 3) begin
      send_idle_pct = 50;
      recv_idle_pct = 26;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= w.op;
    in_point_index <= w.slot;
    in_joint_in_0  <= w.joint[0];
    in_joint_in_1  <= w.joint[1];
    in_joint_in_2  <= w.joint[2];
    in_joint_in_3  <= w.joint[3];
    in_joint_in_4  <= w.joint[4];
    in_joint_in_5  <= w.joint[5];
    in_elapsed_ms  <= w.elapsed_ms;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(w);
    if (w.op != OP_NONE) words_sent++;
  endtask

  task automatic load_point(input int unsigned slot);
    cmd_t w;
    w      = random_word(OP_LOAD);
    w.slot = IDX_W'(slot);
    send_word(w);
  endtask

  task automatic start_motion();
    send_word(random_word(OP_START));
  endtask

  task automatic tick(input logic [ELEM_W-1:0] el);
    cmd_t w;
    w            = random_word(OP_TICK);
    w.elapsed_ms = el;
    send_word(w);
  endtask

  // Register write once the block has drained
  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.poses_waiting() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  // With a valid config: load every point in use, start, ticks, end of motion
  task automatic run_motion();
    int unsigned used, total, el, k, n, r;
    used = sb.used_points();
    if (sb.seg_dur == 0 || used < 2) begin
      start_motion();
      repeat ($urandom_range(1, 3)) tick($urandom());
      return;
    end
    for (k = 0; k < used; k++) load_point(k);
    start_motion();
    total = sb.seg_dur * (used - 1);
    n     = $urandom_range(2, 14);
    el    = 0;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 5) begin
        send_word(random_word(OP_NONE));
      end else if (r < 12) begin
        load_point($urandom_range(used - 1));
      end else if (r < 30) begin
        tick($urandom_range(total - 1));
      end else begin
        el = el + $urandom_range(total / n);
        if (el >= total) el = $urandom_range(total - 1);
        tick(el);
      end
    end
    // sometimes leave the motion running
    if ($urandom_range(9) == 0) return;
    case ($urandom_range(3))
      0:       tick(total);
      1:       tick(32'hFFFF_FFFF);
      2:       tick(total + $urandom_range(1000));
      default: tick($urandom_range(32'hFFFF_FFFF, total));
    endcase
    if ($urandom_range(3) == 0) tick($urandom());
  endtask

  // Stimulus
  initial begin : stimulus
    cmd_t            w;
    logic [DUR_W-1:0] dur;
    logic [CNT_W-1:0] cnt;
    int unsigned      r;
    bit               first;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: opposite extremes on two points, default 1000 ms / 2 points
    w       = random_word(OP_LOAD);
    w.slot  = 0;
    w.joint = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h1234_5678,
                32'hFFFF_0000};
    send_word(w);
    w.slot  = 1;
    w.joint = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0000_0001, 32'hEDCB_A987,
                32'h0001_0000};
    send_word(w);
    tick(0);                                    // tick while idle
    send_word(random_word(OP_NONE));            // unknown operation
    start_motion();
    tick(0);
    tick(1);
    tick(500);
    tick(999);
    load_point(1);                              // load during motion
    tick(750);
    tick(1000);                                 // exactly at the end
    tick(500);                                  // idle again
    start_motion();
    tick(32'hFFFF_FFFF);

    // Bad configuration: start ignored
    set_reg(CFG_POINT_CNT, 16'd1);
    start_motion();
    tick(10);
    set_reg(CFG_POINT_CNT, 16'd0);
    start_motion();
    set_reg(CFG_POINT_CNT, 16'd2);
    set_reg(CFG_SEG_DUR, 16'd0);
    start_motion();

    // Bad configuration while running: motion cleared, no result
    set_reg(CFG_SEG_DUR, 16'd1000);
    start_motion();
    set_reg(CFG_SEG_DUR, 16'd0);
    tick(100);
    tick(100);

    // Random motions over varied settings
    first = 1'b1;
    while (words_sent < RANDOM_WORDS) begin
      if (first || $urandom_range(3) == 0) begin
        first = 1'b0;
        r = $urandom_range(99);
        if (r < 3)       dur = '0;
        else if (r < 13) dur = 16'd1;
        else if (r < 18) dur = 16'd2;
        else if (r < 25) dur = 16'hFFFF;
        else if (r < 35) dur = 16'd1000;
        else             dur = DUR_W'($urandom_range(1, 16'hFFFF));
        r = $urandom_range(99);
        if (r < 4)      cnt = CNT_W'($urandom_range(1));
        else if (r < 9) cnt = CNT_W'($urandom_range(64, 127));
        else            cnt = CNT_W'($urandom_range(2, 6));
        set_reg(CFG_SEG_DUR, dur);
        set_reg(CFG_POINT_CNT, CFG_DATA_W'(cnt));
      end
      run_motion();
    end

    // Drain and report
    in_valid <= 1'b0;
    while (sb.poses_waiting() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
